FILE: sv/gpoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpoc_pkg;

    // Cell coordinate width on the board
    localparam int CoordW = 3;

    typedef logic [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord first_start_row;
        t_coord first_start_col;
        t_coord first_end_row;
        t_coord first_end_col;
        t_coord second_start_row;
        t_coord second_start_col;
        t_coord second_end_row;
        t_coord second_end_col;
    } t_in_item;

    typedef struct packed {
        logic overlap;
        logic endpoint_only;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture a new transaction and set both walkers to their starts
        logic step;   // advance the nested walk by one cell pair
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic irregular;  // a path is neither straight nor diagonal
        logic ends_hit;   // some endpoint of one path equals an endpoint of the other
        logic match;      // current cell of A equals current cell of B
        logic last_j;     // B walker sits on its end cell
        logic last_i;     // A walker sits on its end cell
    } t_dp_status;

endpackage

`default_nettype wire

FILE: sv/gpoc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module gpoc_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire gpoc_pkg::t_in_item i_item,
    input  wire gpoc_pkg::t_dp_cmd  i_cmd,
    output gpoc_pkg::t_dp_status o_status
);

    // Distance between two coordinates
    function automatic gpoc_pkg::t_coord f_absdiff(input gpoc_pkg::t_coord a,
                                                   input gpoc_pkg::t_coord b);
        f_absdiff = (a > b) ? gpoc_pkg::t_coord'(a - b) : gpoc_pkg::t_coord'(b - a);
    endfunction

    // Unit step from start toward end, modulo the coordinate width
    function automatic gpoc_pkg::t_coord f_step(input gpoc_pkg::t_coord from,
                                                input gpoc_pkg::t_coord to);
        if (to > from)      f_step = gpoc_pkg::t_coord'(1);
        else if (to < from) f_step = '1;
        else                f_step = '0;
    endfunction

    gpoc_pkg::t_in_item r_ends;
    gpoc_pkg::t_coord   r_ar, r_ac, r_br, r_bc;
    gpoc_pkg::t_coord   r_i, r_j;

    gpoc_pkg::t_coord a_dr, a_dc, b_dr, b_dc, a_len, b_len;
    gpoc_pkg::t_coord a_sr, a_sc, b_sr, b_sc;
    logic             a_reg, b_reg;

    // Classify both stored paths
    always_comb begin
        a_dr  = f_absdiff(r_ends.first_end_row, r_ends.first_start_row);
        a_dc  = f_absdiff(r_ends.first_end_col, r_ends.first_start_col);
        b_dr  = f_absdiff(r_ends.second_end_row, r_ends.second_start_row);
        b_dc  = f_absdiff(r_ends.second_end_col, r_ends.second_start_col);
        a_len = (a_dr > a_dc) ? a_dr : a_dc;
        b_len = (b_dr > b_dc) ? b_dr : b_dc;
        a_sr  = f_step(r_ends.first_start_row, r_ends.first_end_row);
        a_sc  = f_step(r_ends.first_start_col, r_ends.first_end_col);
        b_sr  = f_step(r_ends.second_start_row, r_ends.second_end_row);
        b_sc  = f_step(r_ends.second_start_col, r_ends.second_end_col);
        a_reg = (a_dr == '0) || (a_dc == '0) || (a_dr == a_dc);
        b_reg = (b_dr == '0) || (b_dc == '0) || (b_dr == b_dc);
    end

    // Report status
    always_comb begin
        o_status.irregular = !a_reg || !b_reg;
        o_status.ends_hit =
            (r_ends.first_start_row == r_ends.second_start_row &&
             r_ends.first_start_col == r_ends.second_start_col) ||
            (r_ends.first_start_row == r_ends.second_end_row &&
             r_ends.first_start_col == r_ends.second_end_col) ||
            (r_ends.first_end_row == r_ends.second_start_row &&
             r_ends.first_end_col == r_ends.second_start_col) ||
            (r_ends.first_end_row == r_ends.second_end_row &&
             r_ends.first_end_col == r_ends.second_end_col);
        o_status.match  = (r_ar == r_br) && (r_ac == r_bc);
        o_status.last_j = (r_j == b_len);
        o_status.last_i = (r_i == a_len);
    end

    // Capture endpoints, advance the two walkers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (i_cmd.load) begin
            r_ends <= i_item;
            r_ar   <= i_item.first_start_row;
            r_ac   <= i_item.first_start_col;
            r_br   <= i_item.second_start_row;
            r_bc   <= i_item.second_start_col;
            r_i    <= '0;
            r_j    <= '0;
        end else if (i_cmd.step) begin
            if (o_status.last_j) begin
                r_j  <= '0;
                r_br <= r_ends.second_start_row;
                r_bc <= r_ends.second_start_col;
                r_i  <= r_i + gpoc_pkg::t_coord'(1);
                r_ar <= r_ar + a_sr;
                r_ac <= r_ac + a_sc;
            end else begin
                r_j  <= r_j + gpoc_pkg::t_coord'(1);
                r_br <= r_br + b_sr;
                r_bc <= r_bc + b_sc;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/gpoc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gpoc_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output gpoc_pkg::t_out_item   o_out_item,
    output gpoc_pkg::t_dp_cmd     o_cmd,
    input  wire gpoc_pkg::t_dp_status i_status
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]          r_state, n_state;
    gpoc_pkg::t_out_item r_res, n_res;
    gpoc_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic                out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Sequence one transaction through classify, walk and hand-off
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.irregular) begin
                    n_res.overlap       = i_status.ends_hit;
                    n_res.endpoint_only = 1'b1;
                    n_state             = S_FINISH;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_res.endpoint_only = 1'b0;
                if (i_status.match) begin
                    n_res.overlap = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.last_i && i_status.last_j) begin
                    n_res.overlap = 1'b0;
                    n_state       = S_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_res <= n_res;
    end

    // Output register: load on hand-off, drop on acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= r_res;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: sv/grid_path_overlap_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Checks whether two grid paths, each given by start and end cell, share a
// cell. One transaction is processed at a time: the datapath captures it,
// the paths are classified, then, when both are straight or diagonal, the
// nested walk compares one cell pair per step, at most (lenA+1)*(lenB+1)
// <= 64 pairs and stopping at the first shared cell, and the result is
// handed to the output register once that register is free. The walk is
// paced by the single cell comparator in the datapath. Irregular paths skip
// the walk and compare endpoints only (endpoint_only set). The next
// transaction is accepted while the previous result waits to be taken.
module grid_path_overlap_check (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire gpoc_pkg::t_in_item i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output gpoc_pkg::t_out_item  o_out_item
);

    gpoc_pkg::t_dp_cmd    s_cmd;
    gpoc_pkg::t_dp_status s_status;

    gpoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (s_cmd),
        .i_status    (s_status)
    );

    gpoc_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (s_cmd),
        .o_status (s_status)
    );

    // Load and step never coincide
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_cmd.load && s_cmd.step))
        else $error("load and step issued together");

    // Never walk past a shared cell
    a_no_step_on_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.step |-> !s_status.match)
        else $error("walk advanced past a match");

    // Irregular paths are never walked
    a_no_step_irregular: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.step |-> !s_status.irregular)
        else $error("walk on irregular path");

    // Busy right after accepting a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

endmodule

`default_nettype wire
